FILE: design/binary_to_roman_numeral_core_assert.svh
// Assertion macros shared by the checker of the Roman numeral converter.
`ifndef BINARY_TO_ROMAN_NUMERAL_CORE_ASSERT_SVH
`define BINARY_TO_ROMAN_NUMERAL_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BRN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BRN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/brn_pkg.sv
// Types, constants and symbol tables of the Roman numeral converter.
package brn_pkg;

  localparam logic [11:0] ValueMax = 12'd3999;

  localparam logic [7:0] CharNone = 8'h00;
  localparam logic [7:0] CharI    = 8'h49;
  localparam logic [7:0] CharV    = 8'h56;
  localparam logic [7:0] CharX    = 8'h58;
  localparam logic [7:0] CharL    = 8'h4C;
  localparam logic [7:0] CharC    = 8'h43;
  localparam logic [7:0] CharD    = 8'h44;
  localparam logic [7:0] CharM    = 8'h4D;

  // One classified number: decimal digits, or the out-of-range flag.
  typedef struct packed {
    logic       err;
    logic [1:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } item_t;

  typedef enum logic [1:0] {
    POS_THOU,
    POS_HUND,
    POS_TENS,
    POS_UNITS
  } pos_e;

  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_e;

  // Number of symbols that one decimal digit takes.
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Which symbol of the one/five/ten triple stands at place idx of digit d.
  function automatic sym_e digit_sym(input logic [3:0] d, input logic [1:0] idx);
    sym_e s;
    priority if (d == 4'd9) begin
      s = (idx == 2'd0) ? SYM_ONE : SYM_TEN;
    end else if (d == 4'd4) begin
      s = (idx == 2'd0) ? SYM_ONE : SYM_FIVE;
    end else if (d >= 4'd5) begin
      s = (idx == 2'd0) ? SYM_FIVE : SYM_ONE;
    end else begin
      s = SYM_ONE;
    end
    return s;
  endfunction

  function automatic logic [7:0] sym_char(input pos_e pos, input sym_e s);
    logic [7:0] c;
    c = CharNone;
    unique case (pos)
      POS_THOU: c = CharM;
      POS_HUND: begin
        unique case (s)
          SYM_ONE:  c = CharC;
          SYM_FIVE: c = CharD;
          SYM_TEN:  c = CharM;
          default:  c = CharNone;
        endcase
      end
      POS_TENS: begin
        unique case (s)
          SYM_ONE:  c = CharX;
          SYM_FIVE: c = CharL;
          SYM_TEN:  c = CharC;
          default:  c = CharNone;
        endcase
      end
      POS_UNITS: begin
        unique case (s)
          SYM_ONE:  c = CharI;
          SYM_FIVE: c = CharV;
          SYM_TEN:  c = CharX;
          default:  c = CharNone;
        endcase
      end
      default: c = CharNone;
    endcase
    return c;
  endfunction

endpackage

FILE: design/brn_front.sv
// Front end: takes numbers in, checks the range and splits them into decimal digits.
module brn_front import brn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [11:0] value_i,
  output logic        push_valid_o,
  output item_t       push_item_o,
  input  logic        push_ready_i
);

  // Reciprocals that give exact quotients for every 12-bit value.
  localparam logic [12:0] Recip1000 = 13'd4195;
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam logic [11:0] Recip10   = 12'd3277;

  logic        s_valid_q;
  logic        err_q;
  logic [1:0]  thou_q;
  logic [5:0]  q100_q;
  logic [8:0]  q10_q;
  logic [11:0] value_q;

  logic [24:0] p1000;
  logic [24:0] p100;
  logic [23:0] p10;
  logic        load;

  function automatic logic [3:0] times10_low(input logic [3:0] n);
    logic [6:0] t;
    t = {n, 3'b000} + {2'b00, n, 1'b0};
    return t[3:0];
  endfunction

  assign p1000 = {12'd0, value_i} * {12'd0, Recip1000};
  assign p100  = {13'd0, value_i} * {12'd0, Recip100};
  assign p10   = {12'd0, value_i} * {12'd0, Recip10};

  assign stall_o = s_valid_q && !push_ready_i;
  assign load    = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (!s_valid_q || push_ready_i) begin
      s_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q   <= (value_i == 12'd0) || (value_i > ValueMax);
      thou_q  <= p1000[23:22];
      q100_q  <= p100[24:19];
      q10_q   <= p10[23:15];
      value_q <= value_i;
    end
  end

  // Each digit is a quotient minus ten times the next coarser one, taken modulo 16.
  always_comb begin
    push_item_o.err   = err_q;
    push_item_o.thou  = thou_q;
    push_item_o.hund  = q100_q[3:0] - times10_low({2'b00, thou_q});
    push_item_o.tens  = q10_q[3:0] - times10_low(q100_q[3:0]);
    push_item_o.units = value_q[3:0] - times10_low(q10_q[3:0]);
  end

  assign push_valid_o = s_valid_q;

endmodule

FILE: design/brn_queue.sv
// Short first-in first-out queue of classified numbers between front and back end.
module brn_queue import brn_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  item_t push_item_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t             slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push;
  logic              pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(Depth - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: design/brn_back.sv
// Back end: walks the digits of one number and sends out one symbol per transfer.
module brn_back import brn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  item_t      pop_item_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] character_o,
  output logic       last_o,
  output logic       error_o
);

  logic       busy_q;
  item_t      cur_q;
  pos_e       pos_q;
  logic [1:0] idx_q;

  logic       out_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       err_q;

  logic [2:0] cur_len [4];
  logic [2:0] new_len [4];
  logic       seg_end;
  logic       found;
  pos_e       next_pos;
  logic       new_found;
  pos_e       start_pos;
  logic       is_last;
  logic [3:0] cur_digit;
  sym_e       cur_sym;
  logic [7:0] cur_char;
  logic       out_ready;
  logic       fire;
  logic       done;

  function automatic logic [2:0] item_len(input item_t it, input pos_e p);
    logic [2:0] n;
    unique case (p)
      POS_THOU:  n = {1'b0, it.thou};
      POS_HUND:  n = digit_len(it.hund);
      POS_TENS:  n = digit_len(it.tens);
      POS_UNITS: n = digit_len(it.units);
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cur_len[i] = item_len(cur_q, pos_e'(i));
      new_len[i] = item_len(pop_item_i, pos_e'(i));
    end
  end

  // Next position that still has symbols, and the first one for a new number.
  always_comb begin
    found     = 1'b0;
    next_pos  = POS_UNITS;
    new_found = 1'b0;
    start_pos = POS_UNITS;
    for (int i = 0; i < 4; i++) begin
      if (!found && (i > int'(pos_q)) && (cur_len[i] != 3'd0)) begin
        found    = 1'b1;
        next_pos = pos_e'(i);
      end
      if (!new_found && (new_len[i] != 3'd0)) begin
        new_found = 1'b1;
        start_pos = pos_e'(i);
      end
    end
  end

  always_comb begin
    unique case (pos_q)
      POS_THOU:  cur_digit = 4'd1;
      POS_HUND:  cur_digit = cur_q.hund;
      POS_TENS:  cur_digit = cur_q.tens;
      POS_UNITS: cur_digit = cur_q.units;
      default:   cur_digit = 4'd0;
    endcase
    cur_sym  = digit_sym(cur_digit, idx_q);
    cur_char = cur_q.err ? CharNone : sym_char(pos_q, cur_sym);
  end

  assign seg_end   = (({1'b0, idx_q} + 3'd1) == cur_len[pos_q]);
  assign is_last   = cur_q.err || (seg_end && !found);
  assign out_ready = !out_valid_q || !stall_i;
  assign fire      = busy_q && out_ready;
  assign done      = fire && is_last;
  assign pop_o     = pop_valid_i && (!busy_q || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= POS_THOU;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= start_pos;
        idx_q  <= 2'd0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (fire) begin
        if (seg_end) begin
          pos_q <= next_pos;
          idx_q <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
      if (out_ready) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_item_i;
    end
    if (fire) begin
      char_q <= cur_char;
      last_q <= is_last;
      err_q  <= cur_q.err;
    end
  end

  assign valid_o     = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

endmodule

FILE: design/binary_to_roman_numeral_core.sv
// Converts a binary number from 1 to 3999 into its Roman numeral, one ASCII symbol per
// output transfer, most significant first, with last_o on the final symbol. A number of
// zero or above 3999 gives one transfer with error_o and last_o set and character 0.
// The front end splits each number into decimal digits by reciprocal multiplication in
// one registered stage, a queue of QueueDepth entries holds classified numbers, and the
// back end sends one symbol per cycle from its output register unless stall_i holds it. A
// number of n symbols (1 to 15, with 15 for 3888) takes n output transfers, and numbers
// follow one another without gaps while the queue is not empty; a number passes the front
// register, queue and back end before the single output register, which sets the rate.
module binary_to_roman_numeral_core import brn_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [11:0] value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic        error_o
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  brn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  brn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  brn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

FILE: design/brn_checker.sv
// Port-level checker of the Roman numeral converter and its binding to the top level.
`include "binary_to_roman_numeral_core_assert.svh"

module brn_checker import brn_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic [11:0] value_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [7:0]  character_o,
  input logic        last_o,
  input logic        error_o
);

  logic sym_legal;
  assign sym_legal = (character_o == CharI) || (character_o == CharV) ||
                     (character_o == CharX) || (character_o == CharL) ||
                     (character_o == CharC) || (character_o == CharD) ||
                     (character_o == CharM);

  // An error result stands alone and carries no symbol.
  `BRN_ASSERT_IMP(a_err_alone, valid_o && error_o, (character_o == CharNone) && last_o, "error result must be a lone null character")

  // A good result is always one of the seven Roman symbols.
  `BRN_ASSERT_IMP(a_sym_legal, valid_o && !error_o, sym_legal, "illegal Roman symbol")

  // A numeral in progress is never interrupted by an error result.
  `BRN_ASSERT_NXT(a_no_err_midrun, valid_o && !stall_i && !last_o, !(valid_o && error_o), "error result inside a numeral")

  // A stalled result holds until it is taken.
  `BRN_ASSERT_NXT(a_out_hold, valid_o && stall_i, valid_o && $stable(character_o) && $stable(last_o) && $stable(error_o), "stalled result changed")

  // A stalled input number holds until it is taken.
  `BRN_ASSERT_NXT(a_in_hold, valid_i && stall_o, valid_i && $stable(value_i), "stalled input changed")

endmodule

bind binary_to_roman_numeral_core brn_checker u_brn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (valid_i),
  .stall_o     (stall_o),
  .value_i     (value_i),
  .valid_o     (valid_o),
  .stall_i     (stall_i),
  .character_o (character_o),
  .last_o      (last_o),
  .error_o     (error_o)
);

FILE: sim/tb_binary_to_roman_numeral_core.sv
// Self-checking testbench of the binary to Roman numeral converter core.
`timescale 1ns / 1ps

module tb_binary_to_roman_numeral_core import brn_pkg::*; ();

  localparam int NumRandom = 105;
  localparam int IdleLimit = 1000;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       error;
  } symbol_t;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_RANDOM,
    RX_PERIODIC,
    RX_BLOCKS
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic [11:0] value_i = '0;
  logic        stall_i = 1'b0;
  logic        stall_o;
  logic        valid_o;
  logic [7:0]  character_o;
  logic        last_o;
  logic        error_o;

  logic [11:0] numerals_to_send[$];
  symbol_t     roman_symbols_due[$];
  int          mismatches = 0;
  int          tx_burst_left = 1;
  int          tx_gap_left = 0;
  rx_mode_e    rx_mode = RX_FLOW;
  int          rx_mode_left = 20;
  int unsigned rx_tick = 0;
  int          idle_cycles = 0;

  binary_to_roman_numeral_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void push_symbol(logic [7:0] c);
    roman_symbols_due.push_back('{character: c, last: 1'b0, error: 1'b0});
  endfunction

  // One decimal digit in the subtractive form, from its one, five and ten symbols.
  function automatic void predict_digit(int unsigned d, logic [7:0] one, logic [7:0] five,
                                        logic [7:0] ten);
    if (d == 9) begin
      push_symbol(one);
      push_symbol(ten);
    end else if (d == 4) begin
      push_symbol(one);
      push_symbol(five);
    end else if (d >= 5) begin
      push_symbol(five);
      for (int k = 5; k < d; k++) push_symbol(one);
    end else begin
      for (int k = 0; k < d; k++) push_symbol(one);
    end
  endfunction

  function automatic void predict_numeral(logic [11:0] v);
    int unsigned n;
    n = {20'd0, v};
    if (n == 0 || n > ValueMax) begin
      roman_symbols_due.push_back('{character: CharNone, last: 1'b1, error: 1'b1});
    end else begin
      for (int k = 0; k < n / 1000; k++) push_symbol(CharM);
      predict_digit((n / 100) % 10, CharC, CharD, CharM);
      predict_digit((n / 10) % 10, CharX, CharL, CharC);
      predict_digit(n % 10, CharI, CharV, CharX);
      roman_symbols_due[roman_symbols_due.size() - 1].last = 1'b1;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps, some of them empty.
  always @(posedge clk_i) begin
    if (valid_i && !stall_o) predict_numeral(value_i);
    if (!valid_i || !stall_o) begin
      if (!rst_ni || numerals_to_send.size() == 0) begin
        valid_i <= 1'b0;
      end else if (tx_gap_left > 0) begin
        valid_i <= 1'b0;
        tx_gap_left <= tx_gap_left - 1;
      end else begin
        valid_i <= 1'b1;
        value_i <= numerals_to_send.pop_front();
        if (tx_burst_left <= 1) begin
          tx_burst_left <= $urandom_range(1, 12);
          tx_gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          tx_burst_left <= tx_burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall behavior switches between free flow, random, periodic and long blocks.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(16, 80);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_FLOW:     stall_i <= 1'b0;
      RX_RANDOM:   stall_i <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: stall_i <= (rx_tick % 4 == 3);
      default:     stall_i <= (rx_tick % 13 < 7);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (roman_symbols_due.size() == 0) begin
        $error("unexpected symbol transfer: character %h last %b error %b",
               character_o, last_o, error_o);
        mismatches <= mismatches + 1;
      end else begin
        symbol_t due;
        due = roman_symbols_due.pop_front();
        if (character_o !== due.character || last_o !== due.last ||
            error_o !== due.error) begin
          mismatches <= mismatches + 1;
        end
        if (character_o !== due.character)
          $error("character: expected %h, got %h", due.character, character_o);
        if (last_o !== due.last)
          $error("last: expected %b, got %b", due.last, last_o);
        if (error_o !== due.error)
          $error("error: expected %b, got %b", due.error, error_o);
      end
    end
  end

  // Watchdog on cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("tb_binary_to_roman_numeral_core: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int directed_values[] = '{0, 1, 3999, 4000, 4095, 3888, 4, 9, 5, 6, 40, 90, 400, 900,
                              1000, 2000, 3000, 444, 999, 3, 8, 49, 2047, 2730, 1365};
    int pick;
    int unsigned v;

    foreach (directed_values[i]) numerals_to_send.push_back(12'(directed_values[i]));
    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Out of range: zero or anything past the largest numeral.
        v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4000, 4095);
      end else if (pick < 3) begin
        v = $urandom_range(1, 3999);
      end else begin
        v = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
            $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
      end
      numerals_to_send.push_back(v[11:0]);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numerals_to_send.size() != 0 || valid_i) @(posedge clk_i);
    while (roman_symbols_due.size() != 0) @(posedge clk_i);
    // Any stray transfer after the last numeral shows up within the pipeline depth.
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_binary_to_roman_numeral_core: done, clean");
    end else begin
      $display("tb_binary_to_roman_numeral_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: binary_to_roman_numeral_core.f
+incdir+design
design/brn_pkg.sv
design/brn_front.sv
design/brn_queue.sv
design/brn_back.sv
design/binary_to_roman_numeral_core.sv
design/brn_checker.sv
sim/tb_binary_to_roman_numeral_core.sv
